>>> hdl/wdsf_pkg.sv
// ----------------------------------------------------------------------------
// wdsf_pkg: shared types and constants
// Command codes, register indexes, reset values and the front/back queue entry.
// ----------------------------------------------------------------------------
package wdsf_pkg;

   localparam int WINDOW_DEPTH_DEF = 64;
   localparam int STAMP_W = 32;
   localparam int DEPTH_W = 20;
   localparam int MINE_W = 7;
   localparam int CFG16_W = 16;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] REG_MIN_ENTRIES = 2'd0;
   localparam logic [1:0] REG_SPAN_MS = 2'd1;
   localparam logic [1:0] REG_SIGMA_MULT = 2'd2;
   localparam logic [1:0] REG_CUTOFF = 2'd3;

   localparam logic [MINE_W-1:0] MIN_ENTRIES_RST = 7'd4;
   localparam logic [CFG16_W-1:0] SPAN_MS_RST = 16'd2000;
   localparam logic [CFG16_W-1:0] SIGMA_MULT_RST = 16'd768;
   localparam logic [CFG16_W-1:0] CUTOFF_RST = 16'd150;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_QUERY,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type op;
      logic [STAMP_W-1:0] stamp;
      logic signed [DEPTH_W-1:0] depth;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_TEST,
      ST_DROP,
      ST_TRIM,
      ST_APPEND,
      ST_MATH1,
      ST_MATH2,
      ST_MATH3,
      ST_DIVIDE,
      ST_EMIT
   } back_state_type;

endpackage

>>> hdl/wdsf_front.sv
// ----------------------------------------------------------------------------
// wdsf_front: command decode and job queue
// Accepts request words, drops unused codes and queues jobs for the back end.
// ----------------------------------------------------------------------------
module wdsf_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [1:0] req_command,
   input logic [wdsf_pkg::STAMP_W-1:0] req_stamp_ms,
   input logic signed [wdsf_pkg::DEPTH_W-1:0] req_depth_mm,
   output logic job_valid,
   input logic job_ready,
   output wdsf_pkg::job_type job
);

   wdsf_pkg::job_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic push, pop, keep;
   wdsf_pkg::job_type nj;

   assign req_ready = (cnt_ff != 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job = q_ff[rd_ff];
   assign pop = job_valid && job_ready;

   always_comb begin
      keep = 1'b1;
      nj.stamp = req_stamp_ms;
      nj.depth = req_depth_mm;
      case (req_command)
         wdsf_pkg::CMD_SAMPLE: nj.op = wdsf_pkg::OP_SAMPLE;
         wdsf_pkg::CMD_QUERY: nj.op = wdsf_pkg::OP_QUERY;
         wdsf_pkg::CMD_CLEAR: nj.op = wdsf_pkg::OP_CLEAR;
         default: begin
            nj.op = wdsf_pkg::OP_SAMPLE;
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_valid && req_ready && keep;

   always_comb begin
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      if (push) begin
         wr_in = ~wr_ff;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= nj;
      end
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0) else $error("pop of empty queue");
`endif

endmodule

>>> hdl/wdsf_back.sv
// ----------------------------------------------------------------------------
// wdsf_back: window engine
// Walks eviction, keeps the ring and sums, tests spread and divides the sum.
// ----------------------------------------------------------------------------
module wdsf_back #(
   parameter int WINDOW_DEPTH = wdsf_pkg::WINDOW_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic job_valid,
   output logic job_ready,
   input wdsf_pkg::job_type job,
   input logic [wdsf_pkg::MINE_W-1:0] min_entries,
   input logic [wdsf_pkg::CFG16_W-1:0] span_ms,
   input logic [wdsf_pkg::CFG16_W-1:0] sigma_mult_q8,
   input logic [wdsf_pkg::CFG16_W-1:0] cutoff_mm,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic rsp_kind,
   output logic signed [wdsf_pkg::DEPTH_W-1:0] rsp_mean_mm,
   output logic rsp_steady,
   output logic rsp_reached_steady
);

   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int SW = wdsf_pkg::DEPTH_W + CW;       // sum width
   localparam int QW = 2 * wdsf_pkg::DEPTH_W + CW;   // square sum width
   localparam int EW = wdsf_pkg::STAMP_W + wdsf_pkg::DEPTH_W;
   localparam int PW = QW + CW;                       // spread width
   localparam int HW = (PW + 1) / 2;                  // low half of spread
   localparam int LW = PW + 32;                       // lhs width
   localparam int RW = 2 * CW + 48;                   // rhs width
   localparam int DW = SW + 1;                        // divider width

   logic [EW-1:0] ring [WINDOW_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;

   wdsf_pkg::back_state_type state_ff, state_in;
   wdsf_pkg::job_type job_ff;
   logic [AW-1:0] oldest_ff;
   logic [CW-1:0] count_ff;
   logic signed [SW-1:0] sum_ff;
   logic [QW-1:0] sqsum_ff;
   logic sticky_ff;

   logic [PW-1:0] nsq_ff;
   logic [2*SW-1:0] ssq_ff;
   logic [PW-1:0] spread_ff;
   logic [31:0] m2_ff;
   logic [2*CW-1:0] n2_ff;
   logic [31:0] c2_ff;
   logic [HW+31:0] lhs_lo_ff;
   logic [PW-HW+31:0] lhs_hi_ff;
   logic [LW-1:0] lhs_ff;
   logic [RW-1:0] rhs_ff;
   logic steady_ff;

   logic [DW-1:0] rem_ff;
   logic [SW-1:0] quo_ff;
   logic [SW-1:0] mag_ff;
   logic neg_ff;
   logic [$clog2(SW+1)-1:0] bit_ff;

   logic out_v_ff, out_kind_ff, out_steady_ff, out_reach_ff;
   logic signed [wdsf_pkg::DEPTH_W-1:0] out_mean_ff;

   logic signed [wdsf_pkg::DEPTH_W-1:0] old_depth;
   logic [wdsf_pkg::DEPTH_W-1:0] old_mag, new_mag;
   logic [SW-1:0] sum_mag;
   logic [wdsf_pkg::STAMP_W-1:0] old_stamp;
   logic outdated;
   logic [AW-1:0] wr_slot;
   logic [DW-1:0] rem_sh;
   logic [DW-1:0] cnt_ext;
   logic rem_ge;
   logic signed [SW:0] mean_wide;

   assign old_stamp = rd_data_ff[EW-1 -: wdsf_pkg::STAMP_W];
   assign old_depth = rd_data_ff[wdsf_pkg::DEPTH_W-1:0];
   assign old_mag = old_depth[wdsf_pkg::DEPTH_W-1] ? -old_depth : old_depth;
   assign new_mag = job_ff.depth[wdsf_pkg::DEPTH_W-1] ? -job_ff.depth : job_ff.depth;
   assign sum_mag = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign outdated = (job_ff.stamp > old_stamp) &&
      ((job_ff.stamp - old_stamp) > {16'd0, span_ms});
   assign rd_addr = oldest_ff;

   always_comb begin
      logic [AW:0] s;
      s = {1'b0, oldest_ff} + count_ff[AW:0];
      if (s >= AW'(0) + (AW+1)'(WINDOW_DEPTH)) begin
         s = s - (AW+1)'(WINDOW_DEPTH);
      end
      wr_slot = s[AW-1:0];
   end

   assign cnt_ext = DW'(count_ff);
   assign rem_sh = {rem_ff[DW-2:0], mag_ff[bit_ff - 1'b1]};
   assign rem_ge = rem_sh >= cnt_ext;
   assign mean_wide = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   assign job_ready = (state_ff == wdsf_pkg::ST_IDLE) && !out_v_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wdsf_pkg::ST_IDLE: if (job_valid && job_ready) begin
            state_in = (job.op == wdsf_pkg::OP_SAMPLE) ? wdsf_pkg::ST_READ
               : wdsf_pkg::ST_IDLE;
         end
         wdsf_pkg::ST_READ: state_in = wdsf_pkg::ST_TEST;
         wdsf_pkg::ST_TEST: begin
            // the walk stops at the first kept entry; a full ring then drops one
            if (count_ff != '0 && outdated) begin
               state_in = wdsf_pkg::ST_DROP;
            end else if (count_ff == CW'(WINDOW_DEPTH)) begin
               state_in = wdsf_pkg::ST_TRIM;
            end else begin
               state_in = wdsf_pkg::ST_APPEND;
            end
         end
         wdsf_pkg::ST_DROP: state_in = wdsf_pkg::ST_READ;
         wdsf_pkg::ST_TRIM: state_in = wdsf_pkg::ST_APPEND;
         wdsf_pkg::ST_APPEND: state_in = wdsf_pkg::ST_MATH1;
         wdsf_pkg::ST_MATH1: state_in = (CW'(count_ff) > CW'(0) &&
            {1'b0, count_ff} > (CW+1)'(min_entries)) ? wdsf_pkg::ST_MATH2
            : wdsf_pkg::ST_IDLE;
         wdsf_pkg::ST_MATH2: state_in = wdsf_pkg::ST_MATH3;
         wdsf_pkg::ST_MATH3: state_in = wdsf_pkg::ST_DIVIDE;
         wdsf_pkg::ST_DIVIDE: if (bit_ff == '0) begin
            state_in = wdsf_pkg::ST_EMIT;
         end
         wdsf_pkg::ST_EMIT: state_in = wdsf_pkg::ST_IDLE;
         default: state_in = wdsf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= ring[rd_addr];
      if (state_ff == wdsf_pkg::ST_APPEND) begin
         ring[wr_slot] <= {job_ff.stamp, job_ff.depth};
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         job_ff <= job;
      end
      case (state_ff)
         wdsf_pkg::ST_MATH1: begin
            nsq_ff <= PW'(count_ff) * PW'(sqsum_ff);
            ssq_ff <= (2*SW)'(sum_mag) * (2*SW)'(sum_mag);
            m2_ff <= sigma_mult_q8 * sigma_mult_q8;
            c2_ff <= cutoff_mm * cutoff_mm;
            n2_ff <= count_ff * count_ff;
            mag_ff <= sum_mag;
            neg_ff <= sum_ff[SW-1];
         end
         wdsf_pkg::ST_MATH2: begin
            spread_ff <= nsq_ff - PW'(ssq_ff);
            rhs_ff <= {RW'(c2_ff) * RW'(n2_ff)} << 16;
         end
         wdsf_pkg::ST_MATH3: begin
            // split the spread product into two half-width multiplies
            lhs_lo_ff <= (HW+32)'(spread_ff[HW-1:0]) * (HW+32)'(m2_ff);
            lhs_hi_ff <= (PW-HW+32)'(spread_ff[PW-1:HW]) * (PW-HW+32)'(m2_ff);
            rem_ff <= '0;
            quo_ff <= '0;
            bit_ff <= ($clog2(SW+1))'(SW);
         end
         wdsf_pkg::ST_DIVIDE: begin
            if (bit_ff == ($clog2(SW+1))'(SW)) begin
               lhs_ff <= (LW'(lhs_hi_ff) << HW) + LW'(lhs_lo_ff);
            end
            if (bit_ff == '0) begin
               steady_ff <= lhs_ff < LW'(rhs_ff);
               if (neg_ff && rem_ff != '0) begin
                  quo_ff <= quo_ff + 1'b1;
               end
            end else begin
               rem_ff <= rem_ge ? rem_sh - cnt_ext : rem_sh;
               quo_ff <= {quo_ff[SW-2:0], rem_ge};
               bit_ff <= bit_ff - 1'b1;
            end
         end
         default: ;
      endcase
      if (state_ff == wdsf_pkg::ST_EMIT) begin
         out_kind_ff <= 1'b0;
         out_mean_ff <= mean_wide[wdsf_pkg::DEPTH_W-1:0];
         out_steady_ff <= steady_ff;
         out_reach_ff <= 1'b0;
      end else if (job_valid && job_ready && job.op == wdsf_pkg::OP_QUERY) begin
         out_kind_ff <= 1'b1;
         out_mean_ff <= '0;
         out_steady_ff <= 1'b0;
         out_reach_ff <= sticky_ff;
      end
   end

   // Control and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wdsf_pkg::ST_IDLE;
         oldest_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         sqsum_ff <= '0;
         sticky_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_v_ff && rsp_ready) begin
            out_v_ff <= 1'b0;
         end
         if (job_valid && job_ready) begin
            if (job.op == wdsf_pkg::OP_QUERY) begin
               out_v_ff <= 1'b1;
               sticky_ff <= 1'b0;
            end else if (job.op == wdsf_pkg::OP_CLEAR) begin
               oldest_ff <= '0;
               count_ff <= '0;
               sum_ff <= '0;
               sqsum_ff <= '0;
               sticky_ff <= 1'b0;
            end
         end
         if (state_ff == wdsf_pkg::ST_DROP || state_ff == wdsf_pkg::ST_TRIM) begin
            sum_ff <= sum_ff - SW'(old_depth);
            sqsum_ff <= sqsum_ff - QW'(old_mag) * QW'(old_mag);
            oldest_ff <= (oldest_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
            count_ff <= count_ff - 1'b1;
         end
         if (state_ff == wdsf_pkg::ST_APPEND) begin
            sum_ff <= sum_ff + SW'(job_ff.depth);
            sqsum_ff <= sqsum_ff + QW'(new_mag) * QW'(new_mag);
            count_ff <= count_ff + 1'b1;
         end
         if (state_ff == wdsf_pkg::ST_EMIT) begin
            out_v_ff <= 1'b1;
            if (steady_ff) begin
               sticky_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_mean_mm = out_mean_ff;
   assign rsp_steady = out_steady_ff;
   assign rsp_reached_steady = out_reach_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(WINDOW_DEPTH)) else $error("count above depth");
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == wdsf_pkg::ST_EMIT |-> !out_v_ff) else $error("result overwritten");
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_kind_ff |-> out_mean_ff == '0 && !out_steady_ff)
      else $error("query fields");
`endif

endmodule

>>> hdl/windowed_depth_steadiness_filter.sv
// ----------------------------------------------------------------------------
// windowed_depth_steadiness_filter: sliding-window mean and steadiness test
//
//   channel  direction  handshake               payload
//   req      in         req_valid/req_ready     command, stamp_ms, depth_mm
//   rsp      out        rsp_valid/rsp_ready     kind, mean_mm, steady, reached_steady
//   csr      in         APB psel/penable/pready 4 registers at 4*i
//
// A sample with a result goes from the engine taking it to the result word through
// these steps: read and test the oldest entry, then drop, read and test for each
// evicted entry, trim one more when the ring is full, append, three multiply
// steps, the bit-serial divide by count and the emit. The eviction walk through
// the ring's read port and the divide set the time. A word is registered in the
// queue before the engine sees it; query and clear keep the engine in its idle state.
// A two-entry queue lets requests be taken while the engine works; a waiting
// result stalls the engine, not the queue.
// Reset is synchronous; no clearing pass, the ring reads only written entries.
// ----------------------------------------------------------------------------
module windowed_depth_steadiness_filter #(
   parameter int WINDOW_DEPTH = wdsf_pkg::WINDOW_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [1:0] req_command,
   input logic [31:0] req_stamp_ms,
   input logic signed [19:0] req_depth_mm,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic rsp_kind,
   output logic signed [19:0] rsp_mean_mm,
   output logic rsp_steady,
   output logic rsp_reached_steady,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [3:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   logic [wdsf_pkg::MINE_W-1:0] min_entries_ff;
   logic [15:0] span_ff, mult_ff, cutoff_ff;
   logic job_valid, job_ready;
   wdsf_pkg::job_type job;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   // Register writes; values beyond a field's width are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         min_entries_ff <= wdsf_pkg::MIN_ENTRIES_RST;
         span_ff <= wdsf_pkg::SPAN_MS_RST;
         mult_ff <= wdsf_pkg::SIGMA_MULT_RST;
         cutoff_ff <= wdsf_pkg::CUTOFF_RST;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            wdsf_pkg::REG_MIN_ENTRIES: min_entries_ff <= csr_pwdata[6:0];
            wdsf_pkg::REG_SPAN_MS: span_ff <= csr_pwdata[15:0];
            wdsf_pkg::REG_SIGMA_MULT: mult_ff <= csr_pwdata[15:0];
            wdsf_pkg::REG_CUTOFF: cutoff_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         wdsf_pkg::REG_MIN_ENTRIES: csr_prdata = {25'd0, min_entries_ff};
         wdsf_pkg::REG_SPAN_MS: csr_prdata = {16'd0, span_ff};
         wdsf_pkg::REG_SIGMA_MULT: csr_prdata = {16'd0, mult_ff};
         wdsf_pkg::REG_CUTOFF: csr_prdata = {16'd0, cutoff_ff};
         default: csr_prdata = '0;
      endcase
   end

   wdsf_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_stamp_ms(req_stamp_ms),
      .req_depth_mm(req_depth_mm),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   wdsf_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_ready(job_ready), .job(job),
      .min_entries(min_entries_ff), .span_ms(span_ff),
      .sigma_mult_q8(mult_ff), .cutoff_mm(cutoff_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_mean_mm(rsp_mean_mm), .rsp_steady(rsp_steady),
      .rsp_reached_steady(rsp_reached_steady)
   );

`ifndef NO_ASSERTIONS
   a_pready: assert property (@(posedge clock) csr_pready) else $error("pready low");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("result dropped");
   a_cfg_reset: assert property (@(posedge clock)
      $past(reset) |-> min_entries_ff == wdsf_pkg::MIN_ENTRIES_RST)
      else $error("config reset");
`endif

endmodule

>>> bench/windowed_depth_steadiness_filter_tb.sv
// ----------------------------------------------------------------------------
// windowed_depth_steadiness_filter_tb: self-checking bench for the depth filter
// Drives samples, queries and clears through the request channel, writes the
// four registers over the APB port between phases, predicts every result with
// an in-bench model of the sliding window and compares it field by field.
// ----------------------------------------------------------------------------
module windowed_depth_steadiness_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING = 64;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_command = wdsf_pkg::CMD_SAMPLE;
   logic [31:0] req_stamp_ms = '0;
   logic signed [19:0] req_depth_mm = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_kind;
   logic signed [19:0] rsp_mean_mm;
   logic rsp_steady;
   logic rsp_reached_steady;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   windowed_depth_steadiness_filter dut (.*);

   always #10 clock = ~clock;

   // one expected result word
   typedef struct {
      logic kind;
      logic signed [19:0] mean;
      logic steady;
      logic reached;
   } filter_result_type;

   filter_result_type expected_results[$];
   int mismatch_count = 0;
   int orphan_count = 0;

   // predictor state
   logic [6:0] min_entries_q;
   logic [15:0] span_q, mult_q, cutoff_q;
   logic [31:0] ring_stamp[RING];
   logic signed [19:0] ring_depth[RING];
   int unsigned head_slot, fill;
   longint window_sum;
   longint unsigned window_sqsum;
   bit sticky_q;

   // timestamp running clock for well-formed streams
   logic [31:0] now_ms = 32'd1000;
   int hold_off = 0;       // long receiver stall, counted in rsp process
   bit idle_rsp = 0;       // disable random rsp idling when set

   function automatic longint unsigned sq(longint v);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      return m * m;
   endfunction

   function automatic void window_clear();
      head_slot = 0;
      fill = 0;
      window_sum = 0;
      window_sqsum = 0;
   endfunction

   function automatic void evict_head();
      window_sum -= ring_depth[head_slot];
      window_sqsum -= sq(ring_depth[head_slot]);
      head_slot = (head_slot + 1) % RING;
      fill--;
   endfunction

   // Advance the window model by one word and queue its result, if any.
   function automatic void predict_window(logic [1:0] cmd, logic [31:0] stamp,
                                          logic signed [19:0] depth);
      filter_result_type r;
      longint q;
      longint unsigned n, spread;
      logic [127:0] lhs, rhs;
      bit st;
      if (cmd == wdsf_pkg::CMD_QUERY) begin
         r = '{1'b1, '0, 1'b0, sticky_q};
         sticky_q = 0;
         expected_results = {expected_results, r};
         return;
      end
      if (cmd == wdsf_pkg::CMD_CLEAR) begin
         window_clear();
         sticky_q = 0;
         return;
      end
      if (cmd != wdsf_pkg::CMD_SAMPLE) return;
      // drop outdated entries; a later stamp in the ring stops the walk
      while (fill > 0 && stamp > ring_stamp[head_slot]
             && (stamp - ring_stamp[head_slot]) > span_q)
         evict_head();
      if (fill >= RING) evict_head();
      ring_stamp[(head_slot + fill) % RING] = stamp;
      ring_depth[(head_slot + fill) % RING] = depth;
      fill++;
      window_sum += depth;
      window_sqsum += sq(depth);
      if (fill <= min_entries_q) return;
      n = fill;
      q = window_sum / longint'(n);
      if (window_sum % longint'(n) != 0 && window_sum < 0) q--;
      spread = n * window_sqsum - sq(window_sum);
      lhs = 128'(spread) * 128'(longint'(mult_q) * longint'(mult_q));
      rhs = (128'(longint'(cutoff_q) * longint'(cutoff_q)) * 128'(n * n)) << 16;
      st = lhs < rhs;
      if (st) sticky_q = 1;
      r = '{1'b0, q[19:0], st, 1'b0};
      expected_results = {expected_results, r};
   endfunction

   // Send one word: hold valid and payload until the handshake. Valid stays
   // high after the handshake so the next word can follow with no gap.
   task automatic send_word(logic [1:0] cmd, logic [31:0] stamp, logic signed [19:0] depth,
                            bit gaps = 1);
      int gap;
      if (gaps) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_stamp_ms <= stamp;
      req_depth_mm <= depth;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_window(cmd, stamp, depth);
   endtask

   task automatic send_sample(int step_max, logic signed [19:0] depth, bit gaps = 1);
      now_ms = now_ms + $urandom_range(0, step_max);
      send_word(wdsf_pkg::CMD_SAMPLE, now_ms, depth, gaps);
   endtask

   // Register write: setup phase, then access phase.
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         wdsf_pkg::REG_MIN_ENTRIES: min_entries_q = value[6:0];
         wdsf_pkg::REG_SPAN_MS: span_q = value[15:0];
         wdsf_pkg::REG_SIGMA_MULT: mult_q = value[15:0];
         default: cutoff_q = value[15:0];
      endcase
   endtask

   // Drop valid, wait out every expected result, then the engine's tail latency.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic set_config(logic [6:0] me, logic [15:0] sp, logic [15:0] mu,
                             logic [15:0] cu);
      drain();
      write_reg(wdsf_pkg::REG_MIN_ENTRIES, 32'(me));
      write_reg(wdsf_pkg::REG_SPAN_MS, 32'(sp));
      write_reg(wdsf_pkg::REG_SIGMA_MULT, 32'(mu));
      write_reg(wdsf_pkg::REG_CUTOFF, 32'(cu));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Extremes of depth, every command, unused code and a backwards stamp.
   task automatic test_directed();
      send_word(wdsf_pkg::CMD_QUERY, '0, '0);
      send_sample(5, 20'sh7FFFF);
      send_sample(5, -20'sh80000);
      send_sample(5, 20'sh7FFFF);
      send_sample(5, -20'sh80000);
      send_sample(5, 20'sd0);
      send_sample(5, -20'sd1);
      send_word(CMD_UNUSED, 32'hFFFF_FFFF, 20'sh7FFFF);
      // stamp going backwards stays in the window
      send_word(wdsf_pkg::CMD_SAMPLE, now_ms - 32'd10, 20'sd3);
      send_sample(5, 20'sd3);
      send_word(wdsf_pkg::CMD_QUERY, '0, '0);
      send_word(wdsf_pkg::CMD_CLEAR, '0, '0);
      send_word(wdsf_pkg::CMD_QUERY, '0, '0);
      // steady run after clearing
      repeat (7) send_sample(10, 20'sd1500);
      send_word(wdsf_pkg::CMD_QUERY, '0, '0);
      send_word(wdsf_pkg::CMD_QUERY, '0, '0);
      // top stamp then wrap restart
      send_word(wdsf_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 20'sd7);
      send_word(wdsf_pkg::CMD_CLEAR, '0, '0);
   endtask

   // Well-formed sample streams with occasional queries, clears and noise.
   task automatic test_random_phase(int words, int step_max, int spread);
      int base;
      int pick;
      base = $signed($urandom_range(0, 1048575)) - 524288;
      repeat (words) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) send_word(wdsf_pkg::CMD_QUERY, $urandom, 20'($urandom));
         else if (pick < 10) send_word(wdsf_pkg::CMD_CLEAR, $urandom, 20'($urandom));
         else if (pick < 12) send_word(CMD_UNUSED, $urandom, 20'($urandom));
         else if (pick < 16) send_word(wdsf_pkg::CMD_SAMPLE, $urandom, 20'($urandom));
         else if (pick < 18) send_sample(step_max, 20'($urandom));
         else begin
            int d;
            d = base + $signed($urandom_range(0, 2 * spread)) - spread;
            if (d > 524287) d = 524287;
            if (d < -524288) d = -524288;
            send_sample(step_max, 20'(d));
         end
      end
   endtask

   // Long receiver stall while the sender keeps offering, filling the block.
   task automatic test_back_pressure();
      hold_off = 400;
      repeat (12) send_sample(3, 20'($urandom_range(0, 100)), 0);
      send_word(wdsf_pkg::CMD_QUERY, '0, '0, 0);
   endtask

   task automatic test_full_ring();
      send_word(wdsf_pkg::CMD_CLEAR, '0, '0);
      repeat (70) send_sample(1, 20'($urandom_range(0, 50)));
   endtask

   // result checker: compare each accepted word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            orphan_count++;
            if (mismatch_count + orphan_count <= 10)
               $display("unexpected result: kind %0d mean %0d steady %0d reached %0d",
                        rsp_kind, rsp_mean_mm, rsp_steady, rsp_reached_steady);
         end else begin
            filter_result_type e;
            e = expected_results.pop_front();
            if (e.kind !== rsp_kind || e.mean !== rsp_mean_mm || e.steady !== rsp_steady
                || e.reached !== rsp_reached_steady) begin
               mismatch_count++;
               if (mismatch_count + orphan_count <= 10)
                  $display("mismatch: exp k%0d m%0d s%0d r%0d got k%0d m%0d s%0d r%0d",
                           e.kind, e.mean, e.steady, e.reached, rsp_kind, rsp_mean_mm,
                           rsp_steady, rsp_reached_steady);
            end
         end
      end
   end

   // receiver: random stalls, plus a counted long hold-off on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         gap = idle_rsp ? 0 :
               ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid && hold_off == 0) @(posedge clock);
      end
   end

   // watchdog
   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      min_entries_q = wdsf_pkg::MIN_ENTRIES_RST;
      span_q = wdsf_pkg::SPAN_MS_RST;
      mult_q = wdsf_pkg::SIGMA_MULT_RST;
      cutoff_q = wdsf_pkg::CUTOFF_RST;
      sticky_q = 0;
      window_clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(120, 300, 200);
      set_config(7'd0, 16'd1, 16'd0, 16'd0);
      test_random_phase(60, 3, 100);
      set_config(7'd64, 16'd65535, 16'd65535, 16'd65535);
      test_full_ring();
      set_config(7'd2, 16'd500, 16'd256, 16'd65535);
      test_back_pressure();
      test_random_phase(140, 100, 50);
      set_config(7'($urandom_range(0, 8)), 16'($urandom_range(50, 5000)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      idle_rsp = 1;
      test_random_phase(60, 200, 5);
      idle_rsp = 0;
      set_config(7'd1, 16'd65535, 16'd768, 16'd150);
      test_random_phase(100, 1000, 524287);
      drain();
      if (mismatch_count == 0 && orphan_count == 0 && expected_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

>>> sim.f
hdl/wdsf_pkg.sv
hdl/wdsf_front.sv
hdl/wdsf_back.sv
hdl/windowed_depth_steadiness_filter.sv
bench/windowed_depth_steadiness_filter_tb.sv
